// ===== rtl/ftrr_pkg.sv =====
// Shared constants, structs and helper functions for the float trig range reduction core.
package ftrr_pkg;

    // Fixed-point 2/pi, 80 bits held as two 40-bit halves.
    localparam logic [39:0] TWO_OVER_PI_LO = 40'h441529fc27;
    localparam logic [39:0] TWO_OVER_PI_HI = 40'ha2f9836e4e;

    // Limits on twice the input bit pattern.
    localparam logic [31:0] SPECIAL_LOW  = 32'h78921fb6;
    localparam logic [31:0] SPECIAL_HIGH = 32'h9d000000;
    localparam logic [31:0] MERGE_LIMIT  = 32'h8b400000;

    // Exponent offset that turns the binary32 exponent into the product alignment.
    localparam logic [8:0] EXP_BIAS_SHIFT = 9'd150;

    // Low fraction bits that are truncated away.
    localparam int FRAC_DROP_BITS = 10;

    // Binary64 exponent field for a magnitude whose top set bit is bit 63.
    localparam logic [10:0] DBL_EXP_TOP = 11'd1022;

    // Aligned product and control after the multiply stages.
    typedef struct packed {
        logic [63:0] p1;
        logic [39:0] p0_lo;
        logic [5:0]  sh;
        logic [5:0]  lsh;
        logic        merge;
        logic        special;
    } t_prod;

    // Signed fraction split into sign and magnitude, with the count.
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        logic [31:0] count;
        logic        special;
    } t_frac;

    // Leading zero count of one byte; eight for an all-zero byte.
    function automatic logic [3:0] lzc8(input logic [7:0] b);
        logic [3:0] cnt;
        logic       found;
        cnt   = 4'd8;
        found = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if (!found && b[k]) begin
                cnt   = 4'(7 - k);
                found = 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/ftrr_mult.sv =====
// Decode and two-stage significand by 2/pi multiply of the range reduction pipeline.
module ftrr_mult
    import ftrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_float_bits,
    output logic        o_up_ready,
    input  logic        i_down_ready,
    output logic        o_valid,
    output t_prod       o_prod
);

    logic        r_v1;
    logic [63:0] r_p0;
    logic [63:0] r_phi;
    logic [5:0]  r_sh;
    logic [5:0]  r_lsh;
    logic        r_merge;
    logic        r_special;
    logic        r_v2;
    t_prod       r_prod;

    logic [31:0] twice;
    logic [7:0]  expo;
    logic [23:0] sig;
    logic [63:0] n_p0;
    logic [63:0] n_phi;
    logic        ready1;
    logic        ready2;

    // Ready chain lets bubbles fill while the output side stalls.
    assign ready2     = !r_v2 || i_down_ready;
    assign ready1     = !r_v1 || ready2;
    assign o_up_ready = ready1;

    // Field decode and the two partial products.
    assign twice = {i_float_bits[30:0], 1'b0};
    assign expo  = i_float_bits[30:23];
    assign sig   = {1'b1, i_float_bits[22:0]};
    assign n_p0  = sig * TWO_OVER_PI_LO;
    assign n_phi = sig * TWO_OVER_PI_HI;

    // Stage one: products and shift amounts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_valid;
        end
        if (ready1 && i_valid) begin
            r_p0      <= n_p0;
            r_phi     <= n_phi;
            r_sh      <= 6'(EXP_BIAS_SHIFT + 9'd33 - {1'b0, expo});
            r_lsh     <= 6'({1'b0, expo} + 9'd31 - EXP_BIAS_SHIFT);
            r_merge   <= twice > MERGE_LIMIT;
            r_special <= (twice < SPECIAL_LOW) || (twice >= SPECIAL_HIGH);
        end
    end

    // Stage two: fold the high part of the low product into the high product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
        if (ready2 && r_v1) begin
            r_prod.p1      <= r_phi + {40'd0, r_p0[63:40]};
            r_prod.p0_lo   <= r_p0[39:0];
            r_prod.sh      <= r_sh;
            r_prod.lsh     <= r_lsh;
            r_prod.merge   <= r_merge;
            r_prod.special <= r_special;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;

endmodule

// ===== rtl/ftrr_align.sv =====
// Exponent alignment, count rounding and sign split of the range reduction pipeline.
module ftrr_align
    import ftrr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_prod i_prod,
    output logic  o_up_ready,
    input  logic  i_down_ready,
    output logic  o_valid,
    output t_frac o_frac
);

    logic        r_v3;
    logic [63:0] r_a;
    logic [31:0] r_n;
    logic        r_special;
    logic        r_v4;
    t_frac       r_frac;

    logic [63:0] low_part;
    logic [63:0] n_a;
    logic [31:0] n_n;
    logic        ready3;
    logic        ready4;

    assign ready4     = !r_v4 || i_down_ready;
    assign ready3     = !r_v3 || ready4;
    assign o_up_ready = ready3;

    // Split the product at the binary point and merge the extra low bits.
    always_comb begin
        low_part = {i_prod.p0_lo, 24'd0} >> i_prod.sh;
        n_a      = (i_prod.p1 << i_prod.lsh) | (i_prod.merge ? low_part : 64'd0);
        n_n      = 32'(i_prod.p1 >> i_prod.sh) + {31'd0, n_a[63]};
        n_a[FRAC_DROP_BITS-1:0] = '0;
    end

    // Stage three: count and truncated signed fraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (ready3) begin
            r_v3 <= i_valid;
        end
        if (ready3 && i_valid) begin
            r_a       <= n_a;
            r_n       <= n_n;
            r_special <= i_prod.special;
        end
    end

    // Stage four: sign and magnitude of the fraction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (ready4) begin
            r_v4 <= r_v3;
        end
        if (ready4 && r_v3) begin
            r_frac.mag     <= r_a[63] ? (64'd0 - r_a) : r_a;
            r_frac.neg     <= r_a[63];
            r_frac.count   <= r_n;
            r_frac.special <= r_special;
        end
    end

    assign o_valid = r_v4;
    assign o_frac  = r_frac;

endmodule

// ===== rtl/ftrr_norm.sv =====
// Leading zero search, normalization and binary64 packing of the range reduction pipeline.
module ftrr_norm
    import ftrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_frac       i_frac,
    output logic        o_up_ready,
    input  logic        i_down_ready,
    output logic        o_valid,
    output logic        o_special,
    output logic [31:0] o_count,
    output logic [63:0] o_double
);

    logic        r_v5;
    t_frac       r_frac;
    logic [5:0]  r_lz;
    logic        r_zero;
    logic        r_v6;
    logic        r_special;
    logic [31:0] r_count;
    logic [63:0] r_double;

    logic [3:0]  byte_lz [8];
    logic [5:0]  n_lz;
    logic        n_zero;
    logic [63:0] shifted;
    logic        ready5;
    logic        ready6;

    assign ready6     = !r_v6 || i_down_ready;
    assign ready5     = !r_v5 || ready6;
    assign o_up_ready = ready5;

    // Per-byte leading zeros, then the first nonzero byte from the top.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            byte_lz[b] = lzc8(i_frac.mag[8*b +: 8]);
        end
        n_lz   = 6'd0;
        n_zero = 1'b1;
        for (int b = 7; b >= 0; b--) begin
            if (n_zero && !byte_lz[b][3]) begin
                n_lz   = 6'(8 * (7 - b)) + {3'd0, byte_lz[b][2:0]};
                n_zero = 1'b0;
            end
        end
    end

    // Stage five: leading zero count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (ready5) begin
            r_v5 <= i_valid;
        end
        if (ready5 && i_valid) begin
            r_frac <= i_frac;
            r_lz   <= n_lz;
            r_zero <= n_zero;
        end
    end

    assign shifted = r_frac.mag << r_lz;

    // Stage six: normalized binary64 and zeroing for special inputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (ready6) begin
            r_v6 <= r_v5;
        end
        if (ready6 && r_v5) begin
            r_special <= r_frac.special;
            r_count   <= r_frac.special ? 32'd0 : r_frac.count;
            if (r_frac.special || r_zero) begin
                r_double <= 64'd0;
            end else begin
                r_double <= {r_frac.neg, DBL_EXP_TOP - {5'd0, r_lz}, shifted[62:11]};
            end
        end
    end

    assign o_valid   = r_v6;
    assign o_special = r_special;
    assign o_count   = r_count;
    assign o_double  = r_double;

endmodule

// ===== rtl/float_trig_range_reduction_core.sv =====
// Top level of the binary32 by 2/pi range reduction pipeline.
//
// Input channel: i_valid, i_float_bits, o_stall. A beat is taken at a rising
// edge with i_valid high and o_stall low. Output channel: o_valid, o_special,
// o_reduced_count, o_fraction_double, i_stall. A beat is delivered at an edge
// with o_valid high and i_stall low.
// Each beat yields one result: the quadrant count and the fraction as a
// binary64 pattern, or a special flag with zero payload for tiny, huge,
// infinite or NaN magnitudes.
// Throughput is one beat per cycle in the absence of stalls; the six stages
// are the decode and multiply, product fold, exponent alignment, sign split,
// leading zero search and normalize/pack registers.
// Each stage holds its own valid bit. When the receiver stalls, the last
// stage holds its result and earlier stages keep filling empty slots, so
// o_stall rises only when every stage holding a beat is blocked.
// Synchronous active-low reset clears all valid bits; nothing is in flight
// afterward and o_valid is low.
module float_trig_range_reduction_core
    import ftrr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_float_bits,
    output logic               o_stall,
    output logic               o_valid,
    output logic               o_special,
    output logic signed [31:0] o_reduced_count,
    output logic [63:0]        o_fraction_double,
    input  logic               i_stall
);

    logic        mult_ready;
    logic        mult_valid;
    t_prod       mult_prod;
    logic        align_ready;
    logic        align_valid;
    t_frac       align_frac;
    logic        norm_ready;
    logic [31:0] norm_count;

    assign o_stall = !mult_ready;

    // Decode and multiply.
    ftrr_mult u_mult (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_float_bits (i_float_bits),
        .o_up_ready   (mult_ready),
        .i_down_ready (align_ready),
        .o_valid      (mult_valid),
        .o_prod       (mult_prod)
    );

    // Alignment and sign split.
    ftrr_align u_align (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (mult_valid),
        .i_prod       (mult_prod),
        .o_up_ready   (align_ready),
        .i_down_ready (norm_ready),
        .o_valid      (align_valid),
        .o_frac       (align_frac)
    );

    // Normalization and packing.
    ftrr_norm u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (align_valid),
        .i_frac       (align_frac),
        .o_up_ready   (norm_ready),
        .i_down_ready (!i_stall),
        .o_valid      (o_valid),
        .o_special    (o_special),
        .o_count      (norm_count),
        .o_double     (o_fraction_double)
    );

    assign o_reduced_count = $signed(norm_count);

`ifndef NO_ASSERTIONS
    // A special result carries an all-zero payload.
    a_special_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_special) |-> (o_reduced_count == 32'sd0 && o_fraction_double == 64'd0))
        else $error("special result with nonzero payload");

    // A zero exponent field only ever appears for a true zero fraction.
    a_no_subnormal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fraction_double[62:52] == 11'd0) |-> (o_fraction_double == 64'd0))
        else $error("denormal or negative zero fraction");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the float trig range reduction core.
module tb_top;
    import ftrr_pkg::*;

    localparam int RANDOM_ARGS = 1050;
    localparam int MAX_WAIT    = 19;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 500000;

    // One expected result beat.
    typedef struct packed {
        logic               special;
        logic signed [31:0] count;
        logic [63:0]        frac;
    } t_reduced;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [31:0]        i_float_bits = '0;
    logic               o_stall;
    logic               o_valid;
    logic               o_special;
    logic signed [31:0] o_reduced_count;
    logic [63:0]        o_fraction_double;
    logic               i_stall = 1'b0;

    logic [31:0] args_pending [$];
    t_reduced    results_due [$];

    int  send_gap = 0;
    int  hold_left = 0;
    int  beats_sent = 0;
    bit  drain_wait = 1'b0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    int  mismatches = 0;
    int  cycles = 0;
    t_reduced want;

    // Corner arguments: zero, both special boundaries, the merge boundary, inf, NaN.
    logic [31:0] corner_args [$] = '{
        32'h00000000, 32'h80000000, 32'h00000001, 32'h00800000,
        32'h3c490fda, 32'h3c490fdb, 32'hbc490fdb, 32'h3c800000,
        32'h3f000000, 32'h3f800000, 32'h3fc90fdb, 32'h40490fdb,
        32'h45a00000, 32'h45a00001, 32'hc5a00001, 32'h4e000000,
        32'h4e7fffff, 32'hce7fffff, 32'h4e800000, 32'h7f7fffff,
        32'h7f800000, 32'hff800000, 32'h7fc00000, 32'hffffffff
    };

    float_trig_range_reduction_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_float_bits      (i_float_bits),
        .o_stall           (o_stall),
        .o_valid           (o_valid),
        .o_special         (o_special),
        .o_reduced_count   (o_reduced_count),
        .o_fraction_double (o_fraction_double),
        .i_stall           (i_stall)
    );

    // Signed 64-bit fixed-point fraction to an exact binary64 pattern.
    function automatic logic [63:0] pack_fraction_double(input logic [63:0] a);
        logic        neg;
        logic [63:0] mag;
        int          top;
        logic [51:0] mant;
        neg = a[63];
        mag = neg ? (64'd0 - a) : a;
        if (mag == 64'd0) begin
            return 64'd0;
        end
        top = 63;
        while (!mag[top]) begin
            top--;
        end
        mant = 52'((mag << (63 - top)) >> 11);
        return {neg, 11'(top + 959), mant};
    endfunction

    // Expected count and fraction for one binary32 argument.
    function automatic t_reduced reduce_by_two_over_pi(input logic [31:0] bits);
        t_reduced    r;
        logic [31:0] twice;
        int          sh;
        logic [63:0] m;
        logic [63:0] p0;
        logic [63:0] p1;
        logic [63:0] a;
        logic [31:0] n;
        r = '0;
        twice = {bits[30:0], 1'b0};
        if (twice < SPECIAL_LOW || twice >= SPECIAL_HIGH) begin
            r.special = 1'b1;
            return r;
        end
        sh = int'(bits[30:23]) - int'(EXP_BIAS_SHIFT);
        m  = {40'd0, 1'b1, bits[22:0]};
        p0 = m * {24'd0, TWO_OVER_PI_LO};
        p1 = m * {24'd0, TWO_OVER_PI_HI} + (p0 >> 40);
        n  = 32'(p1 >> (33 - sh));
        a  = p1 << (31 + sh);
        // Large arguments pull the low product half into the fraction.
        if (twice > MERGE_LIMIT) begin
            a = a | ((p0 << 24) >> (33 - sh));
        end
        if (a[63]) begin
            n = n + 32'd1;
        end
        a = (a >> FRAC_DROP_BITS) << FRAC_DROP_BITS;
        r.count = n;
        r.frac  = pack_fraction_double(a);
        return r;
    endfunction

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("float_trig_range_reduction_core: mismatch");
            $finish;
        end
    end

    // Driver: feeds beats from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                results_due.push_back(reduce_by_two_over_pi(i_float_bits));
                beats_sent++;
                // Let the pipeline run dry at a couple of points.
                if (beats_sent == 30 || beats_sent == 600) begin
                    drain_wait = 1'b1;
                end
            end
            if (i_valid && o_stall) begin
                // A stalled beat holds its payload.
            end else if (drain_wait) begin
                i_valid <= 1'b0;
                if (results_due.size() == 0) begin
                    drain_wait = 1'b0;
                end
            end else if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap--;
            end else if (args_pending.size() > 0) begin
                i_valid      <= 1'b1;
                i_float_bits <= args_pending.pop_front();
                if ($urandom_range(0, 59) == 0) begin
                    tx_quiet = !tx_quiet;
                end
                send_gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls at random and checks each result beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected: special=%0b count=%0d frac=%h",
                           o_special, o_reduced_count, o_fraction_double);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (o_special !== want.special) begin
                        $error("special: expected %0b, got %0b", want.special, o_special);
                        mismatches++;
                    end
                    if (o_reduced_count !== want.count) begin
                        $error("reduced_count: expected %0d, got %0d",
                               want.count, o_reduced_count);
                        mismatches++;
                    end
                    if (o_fraction_double !== want.frac) begin
                        $error("fraction_double: expected %h, got %h",
                               want.frac, o_fraction_double);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 59) == 0) begin
                    rx_quiet = !rx_quiet;
                end
                hold_left = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [31:0] arg;
        foreach (corner_args[k]) begin
            args_pending.push_back(corner_args[k]);
        end
        // Mostly arguments in the reducible range, the rest any pattern.
        for (int k = 0; k < RANDOM_ARGS; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                arg = {1'($urandom), 8'($urandom_range(120, 156)), 23'($urandom)};
            end else begin
                arg = $urandom;
            end
            args_pending.push_back(arg);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (args_pending.size() > 0 || i_valid || results_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("float_trig_range_reduction_core: match");
        end else begin
            $display("float_trig_range_reduction_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ftrr_pkg.sv
rtl/ftrr_mult.sv
rtl/ftrr_align.sv
rtl/ftrr_norm.sv
rtl/float_trig_range_reduction_core.sv
tb/tb_top.sv
